// ----- src/hlcd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and sizes for the header/length/checksum deframer.
// Used by hlcd_rx, hlcd_emit and the top level; depends on nothing.
package hlcd_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

   localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);
   localparam logic [7:0] HDR_FIRST     = 8'hFF;
   localparam logic [7:0] HDR_SECOND    = 8'h55;
   localparam logic [7:0] LEN_ABORT     = 8'hFF;

   localparam logic [1:0] ST_DATA    = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_BADSUM  = 2'd2;
   localparam logic [1:0] ST_TOOLONG = 2'd3;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_SYNC,
      PH_LEN,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_LOAD,
      EM_HOLD
   } emit_state_type;

   typedef struct packed {
      logic             drain;
      logic             single;
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
   } emit_cmd_type;

endpackage

// ----- src/hlcd_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// Holds the payload bytes of the frame in progress; no dependencies.
module hlcd_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/hlcd_rx.sv -----
`timescale 1ns / 1ps
// Frame parser: header hunt, length, checksum and payload writes to the RAM.
// Depends on hlcd_pkg; issues frame report commands to hlcd_emit.
module hlcd_rx (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [7:0]                  rx_byte,
   output logic                        wr_en,
   output logic [hlcd_pkg::ADDR_W-1:0] wr_addr,
   output logic [7:0]                  wr_data,
   output hlcd_pkg::emit_cmd_type      cmd
);

   hlcd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] payload_len;
   logic       body_data;

   assign payload_len = (length_ff == 8'd0) ? 8'd0 : length_ff - 8'd1;
   assign body_data   = count_ff < payload_len;

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            hlcd_pkg::PH_HUNT: begin
               if (rx_byte == hlcd_pkg::HDR_FIRST) phase_in = hlcd_pkg::PH_SYNC;
            end
            hlcd_pkg::PH_SYNC: begin
               phase_in = (rx_byte == hlcd_pkg::HDR_SECOND) ? hlcd_pkg::PH_LEN
                                                            : hlcd_pkg::PH_HUNT;
            end
            hlcd_pkg::PH_LEN: begin
               phase_in = (rx_byte != hlcd_pkg::LEN_ABORT) ? hlcd_pkg::PH_BODY
                                                           : hlcd_pkg::PH_HUNT;
            end
            hlcd_pkg::PH_BODY: begin
               if (!body_data) phase_in = hlcd_pkg::PH_HUNT;
            end
            default: phase_in = hlcd_pkg::PH_HUNT;
         endcase
      end
   end

   always_comb begin
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      if (accept && phase_ff == hlcd_pkg::PH_LEN && rx_byte != hlcd_pkg::LEN_ABORT) begin
         length_in = rx_byte;
         sum_in    = rx_byte;
         count_in  = 8'd0;
      end else if (accept && phase_ff == hlcd_pkg::PH_BODY) begin
         if (body_data) begin
            sum_in   = sum_ff + rx_byte;
            count_in = count_ff + 8'd1;
         end else begin
            length_in = 8'd0;
            count_in  = 8'd0;
            sum_in    = 8'd0;
         end
      end
   end

   always_comb begin
      wr_en      = accept && phase_ff == hlcd_pkg::PH_BODY && body_data &&
                   count_ff < hlcd_pkg::MAX_PAYLOAD_B;
      wr_addr    = count_ff[hlcd_pkg::ADDR_W-1:0];
      wr_data    = rx_byte;
      cmd.drain  = 1'b0;
      cmd.single = 1'b0;
      cmd.status = hlcd_pkg::ST_DATA;
      cmd.count  = count_ff[hlcd_pkg::CNT_W-1:0];
      if (accept && phase_ff == hlcd_pkg::PH_BODY && !body_data) begin
         if (count_ff > hlcd_pkg::MAX_PAYLOAD_B) begin
            cmd.single = 1'b1;
            cmd.status = hlcd_pkg::ST_TOOLONG;
         end else if (rx_byte != sum_ff) begin
            cmd.single = 1'b1;
            cmd.status = hlcd_pkg::ST_BADSUM;
         end else if (count_ff == 8'd0) begin
            cmd.single = 1'b1;
            cmd.status = hlcd_pkg::ST_EMPTY;
         end else begin
            cmd.drain = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hlcd_pkg::PH_HUNT;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
         sum_ff    <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

// ----- src/hlcd_emit.sv -----
`timescale 1ns / 1ps
// Result sequencer: moves RAM payload bytes or one status into the output register.
// Depends on hlcd_pkg; takes commands from hlcd_rx and drives the rsp_ channel.
module hlcd_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  hlcd_pkg::emit_cmd_type      cmd,
   output logic                        busy,
   output logic                        rd_en,
   output logic [hlcd_pkg::ADDR_W-1:0] rd_addr,
   input  logic [7:0]                  rd_data,
   output logic [7:0]                  payload_byte,
   output logic [1:0]                  status,
   output logic                        last,
   output logic                        valid,
   input  logic                        stall
);

   hlcd_pkg::emit_state_type state_ff, state_in;
   logic [hlcd_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [hlcd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [hlcd_pkg::CNT_W-1:0] idx_inc;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic       xfer;

   assign idx_inc = idx_ff + hlcd_pkg::CNT_W'(1);
   assign xfer    = state_ff == hlcd_pkg::EM_HOLD && !stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hlcd_pkg::EM_IDLE: begin
            if (cmd.drain) state_in = hlcd_pkg::EM_LOAD;
            else if (cmd.single) state_in = hlcd_pkg::EM_HOLD;
         end
         hlcd_pkg::EM_LOAD: state_in = hlcd_pkg::EM_HOLD;
         hlcd_pkg::EM_HOLD: begin
            if (xfer) state_in = last_ff ? hlcd_pkg::EM_IDLE : hlcd_pkg::EM_LOAD;
         end
         default: state_in = hlcd_pkg::EM_IDLE;
      endcase
   end

   always_comb begin
      busy    = state_ff != hlcd_pkg::EM_IDLE;
      valid   = state_ff == hlcd_pkg::EM_HOLD;
      rd_en   = 1'b0;
      rd_addr = idx_inc[hlcd_pkg::ADDR_W-1:0];
      if (state_ff == hlcd_pkg::EM_IDLE && cmd.drain) begin
         rd_en   = 1'b1;
         rd_addr = '0;
      end else if (xfer && !last_ff) begin
         rd_en = 1'b1;
      end
   end

   always_comb begin
      idx_in    = idx_ff;
      count_in  = count_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      unique case (state_ff)
         hlcd_pkg::EM_IDLE: begin
            if (cmd.drain) begin
               idx_in   = '0;
               count_in = cmd.count;
            end else if (cmd.single) begin
               byte_in   = 8'd0;
               status_in = cmd.status;
               last_in   = 1'b1;
            end
         end
         hlcd_pkg::EM_LOAD: begin
            byte_in   = rd_data;
            status_in = hlcd_pkg::ST_DATA;
            last_in   = idx_inc == count_ff;
         end
         hlcd_pkg::EM_HOLD: begin
            if (xfer && !last_ff) idx_in = idx_inc;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hlcd_pkg::EM_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
   end

   assign payload_byte = byte_ff;
   assign status       = status_ff;
   assign last         = last_ff;

endmodule

// ----- src/header_length_checksum_deframer_core.sv -----
`timescale 1ns / 1ps
// Header/length/checksum deframer, top level.
// Depends on hlcd_pkg, hlcd_ram, hlcd_rx and hlcd_emit.
//
// Usage:
//   req_ channel carries one received byte per transfer (req_rx_byte).
//   rsp_ channel carries frame reports: payload bytes with a last mark,
//   or one empty-frame, bad-checksum or too-long status with last set.
//   Header, length and payload bytes are accepted while req_stall is low;
//   req_stall stays low while no report is pending.
//   After a checksum byte, req_stall rises until every result of that frame
//   has been transferred. A single status result is valid in the cycle after
//   the checksum byte is accepted. For a good frame, each payload byte is read
//   from the payload RAM (a registered read) in state EM_LOAD, then held in
//   the output register in EM_HOLD until transferred, before the next read.
//   rsp_stall holds the current result in the output register; nothing is
//   dropped. Payload bytes go into a MAX_PAYLOAD-entry RAM; in longer frames
//   the bytes beyond it are counted and summed only.
//   Reset (synchronous) returns to the header hunt and empties the output;
//   the RAM is not cleared, since only bytes of the current frame are read.
module header_length_checksum_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_rx_byte,
   input  logic       req_valid,
   output logic       req_stall,
   output logic [7:0] rsp_payload_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last,
   output logic       rsp_valid,
   input  logic       rsp_stall
);

   hlcd_pkg::emit_cmd_type      cmd;
   logic                        busy;
   logic                        accept;
   logic                        wr_en;
   logic [hlcd_pkg::ADDR_W-1:0] wr_addr;
   logic [7:0]                  wr_data;
   logic                        rd_en;
   logic [hlcd_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                  rd_data;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   hlcd_rx u_rx (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .cmd     (cmd)
   );

   hlcd_ram #(
      .DEPTH  (hlcd_pkg::MAX_PAYLOAD),
      .WIDTH  (8),
      .ADDR_W (hlcd_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hlcd_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .busy         (busy),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .payload_byte (rsp_payload_byte),
      .status       (rsp_status),
      .last         (rsp_last),
      .valid        (rsp_valid),
      .stall        (rsp_stall)
   );

endmodule

// ----- test/deframer_check_pkg.sv -----
`timescale 1ns / 1ps
// Frame report scoreboard for the header/length/checksum deframer testbench.
// Depends on hlcd_pkg for the phase enum, header constants and status codes.
package deframer_check_pkg;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [1:0] status;
      logic       last;
   } frame_report_type;

   class frame_report_scoreboard;
      hlcd_pkg::phase_type phase;
      logic [7:0]          frame_len;
      logic [7:0]          body_count;
      logic [7:0]          frame_sum;
      logic [7:0]          body_store [hlcd_pkg::MAX_PAYLOAD];
      frame_report_type    report_queue [$];
      int unsigned         mismatches;

      function new();
         phase      = hlcd_pkg::PH_HUNT;
         frame_len  = '0;
         body_count = '0;
         frame_sum  = '0;
         mismatches = 0;
      endfunction

      function void push_report(logic [7:0] data, logic [1:0] status, logic last);
         frame_report_type r;
         r.payload_byte = data;
         r.status       = status;
         r.last         = last;
         report_queue.push_back(r);
      endfunction

      function void note_rx_byte(logic [7:0] rx_byte);
         logic [7:0] body_len;
         int         i;
         case (phase)
            hlcd_pkg::PH_HUNT: begin
               if (rx_byte == hlcd_pkg::HDR_FIRST) phase = hlcd_pkg::PH_SYNC;
            end
            hlcd_pkg::PH_SYNC: begin
               if (rx_byte == hlcd_pkg::HDR_SECOND) phase = hlcd_pkg::PH_LEN;
               else phase = hlcd_pkg::PH_HUNT;
            end
            hlcd_pkg::PH_LEN: begin
               if (rx_byte != hlcd_pkg::LEN_ABORT) begin
                  frame_len  = rx_byte;
                  frame_sum  = rx_byte;
                  body_count = '0;
                  phase      = hlcd_pkg::PH_BODY;
               end else begin
                  phase = hlcd_pkg::PH_HUNT;
               end
            end
            default: begin
               body_len = (frame_len != 8'd0) ? frame_len - 8'd1 : 8'd0;
               if (body_count < body_len) begin
                  if (body_count < hlcd_pkg::MAX_PAYLOAD_B)
                     body_store[int'(body_count)] = rx_byte;
                  frame_sum  = frame_sum + rx_byte;
                  body_count = body_count + 8'd1;
               end else begin
                  if (body_count > hlcd_pkg::MAX_PAYLOAD_B) begin
                     push_report(8'd0, hlcd_pkg::ST_TOOLONG, 1'b1);
                  end else if (rx_byte != frame_sum) begin
                     push_report(8'd0, hlcd_pkg::ST_BADSUM, 1'b1);
                  end else if (body_count == 8'd0) begin
                     push_report(8'd0, hlcd_pkg::ST_EMPTY, 1'b1);
                  end else begin
                     for (i = 0; i < int'(body_count); i++)
                        push_report(body_store[i], hlcd_pkg::ST_DATA,
                                    (i + 1) == int'(body_count));
                  end
                  phase      = hlcd_pkg::PH_HUNT;
                  frame_len  = '0;
                  body_count = '0;
                  frame_sum  = '0;
               end
            end
         endcase
      endfunction

      function void check_result(logic [7:0] data, logic [1:0] status, logic last);
         frame_report_type want;
         if (report_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: byte %02h status %0d last %0d with none expected",
                        data, status, last);
         end else begin
            want = report_queue.pop_front();
            if (want.payload_byte !== data || want.status !== status || want.last !== last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected byte %02h status %0d last %0d, got %02h %0d %0d",
                           want.payload_byte, want.status, want.last, data, status, last);
            end
         end
      endfunction

      function int pending();
         return report_queue.size();
      endfunction

      function void close_out();
         if (report_queue.size() != 0) begin
            mismatches += report_queue.size();
            $display("mismatch: %0d expected results never arrived", report_queue.size());
         end
      endfunction
   endclass

endpackage

// ----- test/header_length_checksum_deframer_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for header_length_checksum_deframer_core: random framed byte streams
// with idling on both channels. Depends on hlcd_pkg and deframer_check_pkg.
module header_length_checksum_deframer_core_tb;

   localparam int ITEM_TARGET = 470;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;

   logic       clock = 1'b0;
   logic       reset;
   logic [7:0] req_rx_byte;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] rsp_payload_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;
   logic       rsp_valid;
   logic       rsp_stall;

   deframer_check_pkg::frame_report_scoreboard sb;
   bit hold_req;
   int fed_items;
   int req_stretch;
   int rsp_stretch;

   always #2 clock = ~clock;

   header_length_checksum_deframer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall)
   );

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int draw_gap(ref int stretch);
      if (stretch > 0) begin
         stretch--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         stretch = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [7:0] draw_payload();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit counted);
      int gap;
      gap = draw_gap(req_stretch);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_rx_byte <= b;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_rx_byte(b);
      if (counted) fed_items++;
   endtask

   task automatic send_frame(input int len, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      send_byte(hlcd_pkg::HDR_FIRST, 1'b1);
      send_byte(hlcd_pkg::HDR_SECOND, 1'b1);
      send_byte(8'(len), 1'b1);
      sum = 8'(len);
      for (i = 1; i < len; i++) begin
         b = draw_payload();
         sum = sum + b;
         send_byte(b, 1'b1);
      end
      if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
      send_byte(sum, 1'b1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic int draw_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 8);
      if (r < 80) return $urandom_range(9, 20);
      if (r < 92) return $urandom_range(21, 33);
      return $urandom_range(34, 40);
   endfunction

   initial begin : main_seq
      logic [7:0] directed [] = '{
         8'h00,                                // noise in the hunt
         8'hFF, 8'h00,                         // wrong second byte
         8'hFF, 8'hFF,                         // 0xFF as second byte
         8'hFF, 8'h55, 8'hFF,                  // length abort
         8'hFF, 8'h55, 8'h00, 8'h00,           // length 0, good
         8'hFF, 8'h55, 8'h01, 8'h02,           // length 1, bad checksum
         8'hFF, 8'h55, 8'h02, 8'hFF, 8'h01     // one payload byte, good
      };
      int  mode;
      int  len;
      logic [7:0] b;
      bit  hold_done;
      bit  pause_done;

      sb          = new();
      hold_req    = 1'b0;
      fed_items   = 0;
      req_stretch = 0;
      rsp_stretch = 0;
      hold_done   = 1'b0;
      pause_done  = 1'b0;
      reset       <= 1'b1;
      req_rx_byte <= 8'h00;
      req_valid   <= 1'b0;
      rsp_stall   <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      fork
         begin : result_sink
            int gap;
            forever begin
               if (hold_req) begin
                  hold_req = 1'b0;
                  rsp_stall <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
               end else begin
                  gap = draw_gap(rsp_stretch);
                  if (gap > 0) begin
                     rsp_stall <= 1'b1;
                     repeat (gap) @(posedge clock);
                  end
               end
               rsp_stall <= 1'b0;
               do @(posedge clock); while (!(rsp_valid && !rsp_stall));
               sb.check_result(rsp_payload_byte, rsp_status, rsp_last);
            end
         end
      join_none

      foreach (directed[i]) send_byte(directed[i], 1'b0);
      wait_drained();

      send_frame(33, 1'b1);
      send_frame(34, 1'b1);
      send_frame(35, 1'b0);

      while (fed_items < ITEM_TARGET) begin
         if (!hold_done && fed_items >= 150) begin
            hold_done = 1'b1;
            hold_req  = 1'b1;
            send_frame(21, 1'b1);
            send_frame(12, 1'b1);
         end
         if (!pause_done && fed_items >= 300) begin
            pause_done = 1'b1;
            wait_drained();
         end
         mode = $urandom_range(0, 99);
         if (mode < 60) begin
            send_frame(draw_length(), 1'b1);
         end else if (mode < 75) begin
            send_frame(draw_length(), 1'b0);
         end else if (mode < 80) begin
            send_byte(hlcd_pkg::HDR_FIRST, 1'b1);
            b = 8'($urandom_range(0, 255));
            if (b == hlcd_pkg::HDR_SECOND) b = 8'hFF;
            send_byte(b, 1'b1);
         end else if (mode < 85) begin
            send_byte(hlcd_pkg::HDR_FIRST, 1'b1);
            send_byte(hlcd_pkg::HDR_SECOND, 1'b1);
            send_byte(hlcd_pkg::LEN_ABORT, 1'b1);
         end else begin
            len = $urandom_range(1, 3);
            repeat (len) send_byte(8'($urandom_range(0, 254)), 1'b0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
